/* rtl/lph_pkg.sv */
// Package: item and result types, field widths and status codes for the hash insert core.
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;

	localparam int KEY_W    = 31;
	localparam int DATA_W   = 32;
	localparam int SIZE_W   = 9;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 2;
	localparam int DIV_CNT_W = $clog2(KEY_W + 1);

	localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_PRESENT  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] payload;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} result_t;

endpackage
`default_nettype wire

/* rtl/lph_rem.sv */
// Bit-serial restoring remainder unit: key mod table size, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lph_rem
	import lph_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [KEY_W-1:0]  dividend,
	input  wire logic [SIZE_W-1:0] divisor,
	output logic                   done,
	output logic [SIZE_W-1:0]      remainder
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]     dvd_q;
	logic [SIZE_W-1:0]    dsr_q;
	logic [SIZE_W-1:0]    rem_q;
	logic [SIZE_W:0]      trial;

	assign trial = {rem_q, dvd_q[KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(KEY_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= SIZE_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[SIZE_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

`ifndef SYNTH
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dsr_q))
		else $error("remainder not below divisor");
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!run_q && $past(run_q)))
		else $error("done without a finished run");
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && !start) |-> (cnt_q != '0))
		else $error("divider running with empty count");
`endif

endmodule
`default_nettype wire

/* rtl/linear_probe_hash_insert_core.sv */
// Top level: open-addressing hash insert with linear probing over an on-chip slot table.
// Flow: the key mod table_size division, then per probe a read state and a compare state,
// for up to n probes, where n is table_size held to the range 2..TABLE_DEPTH.
// One item at a time: busy is high while an item is in flight and is already low when done is shown.
// After reset a clearing pass empties min(TABLE_DEPTH, 512) slots; busy is high.
// The receiver cannot stall: done marks a result for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_insert_core
	import lph_pkg::*;
#(
	parameter int TABLE_DEPTH  = 256,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire item_t             item,
	output logic                   done,
	output result_t                result,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CLR_N  = (TABLE_DEPTH < 512) ? TABLE_DEPTH : 512;
	localparam int CLR_W  = $clog2(CLR_N);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DIV   = 5'b00100,
		S_READ  = 5'b01000,
		S_CHECK = 5'b10000
	} state_t;

	state_t              state_q;
	logic [SIZE_W-1:0]   size_q;
	logic [SIZE_W-1:0]   n_d;
	logic [SIZE_W-1:0]   n_q;
	logic [SIZE_W-1:0]   pos_q;
	logic [SIZE_W-1:0]   probes_q;
	logic [SIZE_W-1:0]   pos_inc;
	logic [SIZE_W-1:0]   probes_inc;
	logic [CLR_W-1:0]    clr_q;
	item_t               item_q;
	logic                done_q;
	result_t             res_q;
	logic                accept;
	logic                rem_done;
	logic [SIZE_W-1:0]   rem;

	logic [KEY_W:0]        tag_mem [TABLE_DEPTH];
	logic [PAYLOAD_BITS-1:0] data_mem [TABLE_DEPTH];
	logic [KEY_W:0]        rd_q;
	logic                  tag_we;
	logic [ADDR_W-1:0]     wr_addr;
	logic [KEY_W:0]        wr_tag;
	logic                  hit_empty;
	logic                  hit_key;

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign pos_inc    = pos_q + 1'b1;
	assign probes_inc = probes_q + 1'b1;
	assign hit_empty  = !rd_q[KEY_W];
	assign hit_key    = (rd_q[KEY_W-1:0] == item_q.key);

	always_comb begin
		n_d = size_q;
		if (size_q < SIZE_MIN) begin
			n_d = SIZE_MIN;
		end
		if (32'(size_q) > TABLE_DEPTH) begin
			n_d = SIZE_W'(TABLE_DEPTH);
		end
	end

	lph_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (item.key),
		.divisor   (n_d),
		.done      (rem_done),
		.remainder (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (hit_empty || hit_key || (probes_inc == n_q)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			n_q    <= n_d;
		end
		if (state_q == S_DIV && rem_done) begin
			pos_q    <= rem;
			probes_q <= '0;
		end
		if (state_q == S_CHECK) begin
			probes_q <= probes_inc;
			pos_q    <= (pos_inc >= n_q) ? '0 : pos_inc;
			if (hit_empty) begin
				res_q.status <= STAT_INSERTED;
				res_q.slot   <= pos_q[SLOT_W-1:0];
			end else if (hit_key) begin
				res_q.status <= STAT_PRESENT;
				res_q.slot   <= pos_q[SLOT_W-1:0];
			end else begin
				res_q.status <= STAT_FULL;
				res_q.slot   <= '0;
			end
		end
	end

	// slot table: valid bit and key per entry, payload alongside
	assign tag_we  = (state_q == S_CLEAR) || ((state_q == S_CHECK) && hit_empty);
	assign wr_addr = (state_q == S_CLEAR) ? ADDR_W'(clr_q) : ADDR_W'(pos_q);
	assign wr_tag  = (state_q == S_CLEAR) ? '0 : {1'b1, item_q.key};

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[wr_addr] <= wr_tag;
		end
		rd_q <= tag_mem[ADDR_W'(pos_q)];
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_CHECK) && hit_empty) begin
			data_mem[wr_addr] <= PAYLOAD_BITS'(item_q.payload);
		end
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTH
	a_done_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_CHECK))
		else $error("result without a probe check");
	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status == STAT_FULL) |-> (res_q.slot == '0))
		else $error("table full with nonzero slot");
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> ((pos_q < n_q) && (probes_q < n_q)))
		else $error("probe outside active table");
	a_rem_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");
`endif

endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench for linear_probe_hash_insert_core: directed and random inserts checked against a shadow table.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import lph_pkg::*;

	localparam int DEPTH = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_we = 1'b0;
	logic [SIZE_W-1:0] cfg_data = '0;
	item_t item = '0;
	logic busy;
	logic done;
	result_t result;

	// shadow of the slot table
	logic [SIZE_W-1:0] shadow_size = SIZE_RESET;
	bit shadow_valid [DEPTH];
	logic [KEY_W-1:0] shadow_key [DEPTH];
	logic [KEY_W-1:0] stored_keys [$];

	result_t pending_results [$];
	int mismatch_count = 0;
	bit idle_on = 1'b1;

	linear_probe_hash_insert_core #(
		.TABLE_DEPTH(DEPTH),
		.PAYLOAD_BITS(DATA_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int active_slots();
		int n;
		n = shadow_size;
		if (n < SIZE_MIN)
			n = SIZE_MIN;
		if (n > DEPTH)
			n = DEPTH;
		return n;
	endfunction

	function automatic result_t predict_insert(input item_t it);
		int n;
		int pos;
		int p;
		result_t r;
		n = active_slots();
		pos = it.key % n;
		r.status = STAT_FULL;
		r.slot = '0;
		for (p = 0; p < n; p++) begin
			if (!shadow_valid[pos]) begin
				shadow_valid[pos] = 1'b1;
				shadow_key[pos] = it.key;
				stored_keys.push_back(it.key);
				r.status = STAT_INSERTED;
				r.slot = pos[SLOT_W-1:0];
				return r;
			end
			if (shadow_key[pos] == it.key) begin
				r.status = STAT_PRESENT;
				r.slot = pos[SLOT_W-1:0];
				return r;
			end
			pos = (pos + 1 >= n) ? 0 : pos + 1;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d",
					$time, result.status, result.slot);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, result.status);
					mismatch_count++;
				end
				if (result.slot !== want.slot) begin
					$display("%0t: slot expected %0d actual %0d",
						$time, want.slot, result.slot);
					mismatch_count++;
				end
			end
		end
	end

	// leaves start high on return; the next call or the drain decides
	task automatic send_item(input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] d);
		item_t it;
		it.key = k;
		it.payload = d;
		while (idle_on && $urandom_range(99, 0) < 36) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(predict_insert(it));
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_table_size(input logic [SIZE_W-1:0] v);
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_size = v;
	endtask

	task automatic test_basic_inserts();
		send_item(31'd0, 32'h0000_0000);
		send_item(31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(31'd0, 32'h5555_5555);
		send_item(31'd256, 32'hAAAA_AAAA);
		send_item(31'd511, 32'h1234_5678);
	endtask

	task automatic test_size_clamp();
		set_table_size(9'd0);
		send_item(31'd4, 32'h0F0F_0F0F);
		send_item(31'd0, 32'hF0F0_F0F0);
		send_item(31'd256, 32'h0000_0001);
		set_table_size(9'd1);
		send_item(31'd3, 32'h8000_0000);
		set_table_size(9'd511);
		send_item(31'd767, 32'hDEAD_BEEF);
		set_table_size(9'd257);
		send_item(31'd1023, 32'hCAFE_F00D);
	endtask

	task automatic test_shrink_while_filled();
		set_table_size(9'd3);
		send_item(31'd5, 32'h1111_1111);
		send_item(31'd2, 32'h2222_2222);
		set_table_size(9'd6);
		send_item(31'd5, 32'h3333_3333);
		send_item(31'd767, 32'h4444_4444);
		send_item(31'h7FFF_FFFF, 32'h7FFF_FFFF);
	endtask

	task automatic test_random_inserts();
		int unsigned sizes [13] = '{2, 9, 16, 5, 64, 33, 128, 1, 256, 100, 511, 7, 256};
		int ph;
		int i;
		int n;
		int unsigned pick;
		logic [KEY_W-1:0] k;
		for (ph = 0; ph < 13; ph++) begin
			set_table_size(sizes[ph][SIZE_W-1:0]);
			idle_on = (ph != 4);
			n = active_slots();
			for (i = 0; i < 55; i++) begin
				pick = $urandom_range(99, 0);
				if (pick < 35 && stored_keys.size() != 0)
					k = stored_keys[$urandom_range(stored_keys.size() - 1, 0)];
				else if (pick < 65)
					k = 31'($urandom_range(4 * n, 0));
				else if (pick < 85)
					k = 31'($urandom());
				else
					k = 31'h7FFF_FFFF - 31'($urandom_range(3 * n, 0));
				send_item(k, $urandom());
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		test_basic_inserts();
		test_size_clamp();
		test_shrink_while_filled();
		test_random_inserts();
		wait_results_drained();
		repeat (600) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
rtl/lph_pkg.sv
rtl/lph_rem.sv
rtl/linear_probe_hash_insert_core.sv
test/tb.sv
